>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the rank table checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define MRAC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked property, checked in every cycle including reset
`define MRAC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> rtl/mrac_pkg.sv
// ---------------------------------------------------------------------------
// mrac_pkg
// widths, verdict codes and helpers for the rank table checker
// ---------------------------------------------------------------------------
package mrac_pkg;

   localparam int MAX_ELEMENTS = 9;
   localparam int ADDR_W       = MAX_ELEMENTS;
   localparam int TABLE_DEPTH  = 1 << MAX_ELEMENTS;
   localparam int RANK_W       = 4;
   localparam int CFG_W        = 4;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int VERDICT_W    = 3;

   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [RANK_W-1:0]    rank_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [VERDICT_W-1:0] verdict_type;

   localparam verdict_type V_PASS   = 3'd0;
   localparam verdict_type V_EMPTY  = 3'd1;
   localparam verdict_type V_BOUND  = 3'd2;
   localparam verdict_type V_INC    = 3'd3;
   localparam verdict_type V_SUBMOD = 3'd4;
   localparam verdict_type V_RECON  = 3'd5;

   // number of set bits in a subset mask
   function automatic cnt_type pop_count(addr_type v);
      cnt_type c;
      c = '0;
      for (int k = 0; k < ADDR_W; k++) begin
         c = c + cnt_type'(v[k]);
      end
      return c;
   endfunction

endpackage

>>> rtl/mrac_ram.sv
// ---------------------------------------------------------------------------
// mrac_ram
// generic ram, one write port, two registered read ports
// ---------------------------------------------------------------------------
module mrac_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

>>> rtl/matroid_rank_axiom_checker.sv
// ---------------------------------------------------------------------------
// matroid_rank_axiom_checker
// loads a subset rank table and checks it against the rank axioms
// ---------------------------------------------------------------------------
// Items on req_ carry one 4-bit rank each, in ascending subset-mask order, and
// are taken one per cycle while the block is loading. Once the last of the
// 2^n entries (n from csr_element_count, saturated to the maximum element
// count) is in, req_ready drops and a small sequencer walks the table through
// one shared compare path and two dual-read RAMs: empty-set rank, popcount
// bound, single-element increment, local submodularity over element pairs,
// then an independent-set rebuild (seed pass, one subset-max sweep per
// element, compare pass). The first failure found in that walk is the
// verdict, returned as one rsp_ item; an item that does not complete a table
// gives no rsp_ item. The walk reads RAM one step at a time, and a failing
// table stops the walk early. Loading resumes while the verdict waits on
// rsp_ready. A csr_ write is taken only while loading and drops any partly
// loaded table.
module matroid_rank_axiom_checker (
   input  logic                         clock,
   input  logic                         reset,
   // rank items
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mrac_pkg::RANK_W-1:0]  req_rank_value,
   // verdict items
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mrac_pkg::VERDICT_W-1:0] rsp_verdict,
   // element count register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mrac_pkg::CFG_W-1:0]   csr_element_count
);

   localparam int CMP_W = mrac_pkg::RANK_W + mrac_pkg::CNT_W;
   localparam int SUM_W = mrac_pkg::RANK_W + 1;

   // sequencer states
   localparam logic [3:0] ST_LOAD     = 4'd0;
   localparam logic [3:0] ST_EMPTY_RD = 4'd1;
   localparam logic [3:0] ST_EMPTY_CK = 4'd2;
   localparam logic [3:0] ST_S_RD     = 4'd3;
   localparam logic [3:0] ST_S_CK     = 4'd4;
   localparam logic [3:0] ST_I_SCAN   = 4'd5;
   localparam logic [3:0] ST_I_CK     = 4'd6;
   localparam logic [3:0] ST_J_SCAN   = 4'd7;
   localparam logic [3:0] ST_J_CK     = 4'd8;
   localparam logic [3:0] ST_INIT_RD  = 4'd9;
   localparam logic [3:0] ST_INIT_WR  = 4'd10;
   localparam logic [3:0] ST_MAX_SCAN = 4'd11;
   localparam logic [3:0] ST_MAX_WR   = 4'd12;
   localparam logic [3:0] ST_CMP_RD   = 4'd13;
   localparam logic [3:0] ST_CMP_CK   = 4'd14;
   localparam logic [3:0] ST_REPORT   = 4'd15;

   // control state
   logic [3:0]            state_ff, state_in;
   mrac_pkg::cnt_type     n_ff, n_in;          // saturated element count
   mrac_pkg::addr_type    lc_ff, lc_in;        // entries loaded so far
   logic                  rsp_valid_ff, rsp_valid_in;

   // walk counters and held operands
   mrac_pkg::addr_type    s_ff, s_in;          // current subset
   mrac_pkg::cnt_type     i_ff, i_in;          // first added element
   mrac_pkg::cnt_type     j_ff, j_in;          // second added element
   mrac_pkg::rank_type    rs_ff, rs_in;        // r(S)
   mrac_pkg::rank_type    rsi_ff, rsi_in;      // r(S+i)
   mrac_pkg::verdict_type pend_ff, pend_in;    // verdict waiting for output reg
   mrac_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;

   // derived values
   mrac_pkg::addr_type    size_mask;
   mrac_pkg::addr_type    bit_i;
   mrac_pkg::addr_type    bit_j;
   mrac_pkg::cnt_type     pop_s;
   logic                  s_last;

   // rank table ram
   logic                  rank_we;
   mrac_pkg::addr_type    rank_rd_a, rank_rd_b;
   mrac_pkg::rank_type    rank_da, rank_db;

   // rebuilt rank ram
   logic                  reb_we;
   mrac_pkg::rank_type    reb_wd;
   mrac_pkg::addr_type    reb_rd_a;
   mrac_pkg::rank_type    reb_da, reb_db;

   assign size_mask = ~({mrac_pkg::ADDR_W{1'b1}} << n_ff);
   assign bit_i     = mrac_pkg::addr_type'(1) << i_ff;
   assign bit_j     = mrac_pkg::addr_type'(1) << j_ff;
   assign pop_s     = mrac_pkg::pop_count(s_ff);
   assign s_last    = (s_ff == size_mask);

   assign req_ready   = (state_ff == ST_LOAD);
   assign csr_ready   = (state_ff == ST_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // load writes the rank table one entry per item
   assign rank_we = req_valid && req_ready;

   // read addresses follow the walk position
   always_comb begin
      rank_rd_a = s_ff;
      rank_rd_b = s_ff | bit_i | bit_j;
      reb_rd_a  = s_ff;
      if (state_ff == ST_I_SCAN) begin
         rank_rd_a = s_ff | bit_i;
      end
      if (state_ff == ST_J_SCAN) begin
         rank_rd_a = s_ff | bit_j;
      end
      if (state_ff == ST_MAX_SCAN) begin
         reb_rd_a = s_ff ^ bit_i;
      end
   end

   // rebuilt store: seed with independent sets, then subset-max sweep
   always_comb begin
      reb_we = (state_ff == ST_INIT_WR) || (state_ff == ST_MAX_WR);
      if (state_ff == ST_INIT_WR) begin
         reb_wd = (CMP_W'(rank_da) == CMP_W'(pop_s)) ? rank_da : '0;
      end else begin
         reb_wd = (reb_da > reb_db) ? reb_da : reb_db;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      lc_in          = lc_ff;
      s_in           = s_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      rs_in          = rs_ff;
      rsi_in         = rsi_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (lc_ff == size_mask) begin
                  // table complete, start the walk at the empty set
                  lc_in    = '0;
                  s_in     = '0;
                  state_in = ST_EMPTY_RD;
               end else begin
                  lc_in = lc_ff + mrac_pkg::addr_type'(1);
               end
            end
            if (csr_valid) begin
               lc_in = '0;
               if (csr_element_count > mrac_pkg::CFG_W'(mrac_pkg::MAX_ELEMENTS)) begin
                  n_in = mrac_pkg::CNT_W'(mrac_pkg::MAX_ELEMENTS);
               end else begin
                  n_in = mrac_pkg::CNT_W'(csr_element_count);
               end
            end
         end
         ST_EMPTY_RD: begin
            state_in = ST_EMPTY_CK;
         end
         ST_EMPTY_CK: begin
            if (rank_da != '0) begin
               pend_in  = mrac_pkg::V_EMPTY;
               state_in = ST_REPORT;
            end else begin
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            state_in = ST_S_CK;
         end
         ST_S_CK: begin
            rs_in = rank_da;
            if (CMP_W'(rank_da) > CMP_W'(pop_s)) begin
               pend_in  = mrac_pkg::V_BOUND;
               state_in = ST_REPORT;
            end else begin
               i_in     = '0;
               state_in = ST_I_SCAN;
            end
         end
         ST_I_SCAN: begin
            if (i_ff == n_ff) begin
               if (s_last) begin
                  s_in     = '0;
                  state_in = ST_INIT_RD;
               end else begin
                  s_in     = s_ff + mrac_pkg::addr_type'(1);
                  state_in = ST_S_RD;
               end
            end else if ((s_ff & bit_i) != '0) begin
               i_in = i_ff + mrac_pkg::cnt_type'(1);
            end else begin
               state_in = ST_I_CK;
            end
         end
         ST_I_CK: begin
            rsi_in = rank_da;
            if ((rank_da < rs_ff) || ((rank_da - rs_ff) > mrac_pkg::rank_type'(1))) begin
               pend_in  = mrac_pkg::V_INC;
               state_in = ST_REPORT;
            end else begin
               j_in     = i_ff + mrac_pkg::cnt_type'(1);
               state_in = ST_J_SCAN;
            end
         end
         ST_J_SCAN: begin
            if (j_ff == n_ff) begin
               i_in     = i_ff + mrac_pkg::cnt_type'(1);
               state_in = ST_I_SCAN;
            end else if ((s_ff & bit_j) != '0) begin
               j_in = j_ff + mrac_pkg::cnt_type'(1);
            end else begin
               state_in = ST_J_CK;
            end
         end
         ST_J_CK: begin
            // r(S+i) + r(S+j) must not fall below r(S) + r(S+i+j)
            if ((SUM_W'(rsi_ff) + SUM_W'(rank_da)) < (SUM_W'(rs_ff) + SUM_W'(rank_db))) begin
               pend_in  = mrac_pkg::V_SUBMOD;
               state_in = ST_REPORT;
            end else begin
               j_in     = j_ff + mrac_pkg::cnt_type'(1);
               state_in = ST_J_SCAN;
            end
         end
         ST_INIT_RD: begin
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            if (s_last) begin
               s_in     = '0;
               i_in     = '0;
               state_in = ST_MAX_SCAN;
            end else begin
               s_in     = s_ff + mrac_pkg::addr_type'(1);
               state_in = ST_INIT_RD;
            end
         end
         ST_MAX_SCAN: begin
            if (i_ff == n_ff) begin
               s_in     = '0;
               state_in = ST_CMP_RD;
            end else if ((s_ff & bit_i) != '0) begin
               state_in = ST_MAX_WR;
            end else if (s_last) begin
               s_in = '0;
               i_in = i_ff + mrac_pkg::cnt_type'(1);
            end else begin
               s_in = s_ff + mrac_pkg::addr_type'(1);
            end
         end
         ST_MAX_WR: begin
            state_in = ST_MAX_SCAN;
            if (s_last) begin
               s_in = '0;
               i_in = i_ff + mrac_pkg::cnt_type'(1);
            end else begin
               s_in = s_ff + mrac_pkg::addr_type'(1);
            end
         end
         ST_CMP_RD: begin
            state_in = ST_CMP_CK;
         end
         ST_CMP_CK: begin
            if (rank_da != reb_da) begin
               pend_in  = mrac_pkg::V_RECON;
               state_in = ST_REPORT;
            end else if (s_last) begin
               pend_in  = mrac_pkg::V_PASS;
               state_in = ST_REPORT;
            end else begin
               s_in     = s_ff + mrac_pkg::addr_type'(1);
               state_in = ST_CMP_RD;
            end
         end
         ST_REPORT: begin
            // hand the verdict to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = pend_ff;
               state_in       = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= '0;
         lc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         lc_ff        <= lc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s_ff           <= s_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      rs_ff          <= rs_in;
      rsi_ff         <= rsi_in;
      pend_ff        <= pend_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   mrac_ram #(
      .WIDTH (mrac_pkg::RANK_W),
      .DEPTH (mrac_pkg::TABLE_DEPTH)
   ) u_rank_ram (
      .clock     (clock),
      .wr_en     (rank_we),
      .wr_addr   (lc_ff),
      .wr_data   (req_rank_value),
      .rd_addr_a (rank_rd_a),
      .rd_data_a (rank_da),
      .rd_addr_b (rank_rd_b),
      .rd_data_b (rank_db)
   );

   mrac_ram #(
      .WIDTH (mrac_pkg::RANK_W),
      .DEPTH (mrac_pkg::TABLE_DEPTH)
   ) u_rebuilt_ram (
      .clock     (clock),
      .wr_en     (reb_we),
      .wr_addr   (s_ff),
      .wr_data   (reb_wd),
      .rd_addr_a (reb_rd_a),
      .rd_data_a (reb_da),
      .rd_addr_b (s_ff),
      .rd_data_b (reb_db)
   );

endmodule

>>> rtl/mrac_checker.sv
// ---------------------------------------------------------------------------
// mrac_checker
// port-level assertions for the rank table checker
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mrac_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mrac_pkg::VERDICT_W-1:0] rsp_verdict,
   input logic                           csr_ready
);

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   // reset leaves no verdict pending and the block loading
   `MRAC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)

   // only defined verdict codes leave the block
   `MRAC_ASSERT(a_verdict_code, clock, reset, rsp_valid |-> rsp_verdict <= mrac_pkg::V_RECON)

   // a new verdict only follows a cycle spent checking
   `MRAC_ASSERT(a_verdict_after_walk, clock, reset, $rose(rsp_valid) |-> $past(!req_ready))

   // the register is only written while tables are loading
   `MRAC_ASSERT(a_csr_while_loading, clock, reset, csr_ready |-> req_ready)

   // a stalled verdict holds
   `MRAC_ASSERT(a_verdict_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_verdict))

endmodule

bind matroid_rank_axiom_checker mrac_checker u_mrac_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_verdict (rsp_verdict),
   .csr_ready   (csr_ready)
);

>>> tb/tb_matroid_rank_axiom_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matroid_rank_axiom_checker
// self-checking bench for the subset rank table checker
// ---------------------------------------------------------------------------
// Rank items stream in from a queue through a clocked driver. Every accepted
// item goes into a local copy of the rank table. When a table is complete,
// its verdict is worked out here and queued. A clocked monitor compares
// each verdict item against the oldest queued verdict. Stimulus is a short
// hand-written set of tables, then phases of random tables. Most random
// tables are true rank functions built from binary vectors: some are left
// intact, some get one corrupted entry, and the rest are noise. The element
// count changes between phases, only when the block is idle.
// ---------------------------------------------------------------------------
module tb_matroid_rank_axiom_checker;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_CYCLES = 400;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // block ports; the inputs are known from time zero
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   mrac_pkg::rank_type    req_rank_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   mrac_pkg::verdict_type rsp_verdict;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [mrac_pkg::CFG_W-1:0] csr_element_count = '0;

   matroid_rank_axiom_checker u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rank_value    (req_rank_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count)
   );

   // ranks waiting to be sent, verdicts waiting to arrive
   mrac_pkg::rank_type    pending_ranks[$];
   mrac_pkg::verdict_type expected_verdicts[$];

   // local copy of the block state
   logic [mrac_pkg::CFG_W-1:0] count_reg = '0;
   int                         loaded = 0;
   mrac_pkg::rank_type         rank_mem [mrac_pkg::TABLE_DEPTH];
   mrac_pkg::rank_type         rebuilt_mem [mrac_pkg::TABLE_DEPTH];

   // one vector per element, used to build true rank tables
   logic [7:0] elem_vec [mrac_pkg::MAX_ELEMENTS];

   int   error_count = 0;
   int   cycle_count = 0;
   int   cur_n = 0;          // effective element count of the current phase
   logic req_taken = 1'b0;   // an item went in at the last rising edge
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_request = 1'b0;
   logic calm_phase = 1'b0;  // no idling on either side in this phase

   // verdict of the table in rank_mem for n elements: first failing check wins
   function automatic mrac_pkg::verdict_type judge_rank_table(input int n);
      int size;
      int a;
      int b;
      int pc;
      size = 1 << n;
      if (rank_mem[0] != 0) return mrac_pkg::V_EMPTY;
      for (int s = 0; s < size; s++) begin
         if (rank_mem[s] > $countones(s)) return mrac_pkg::V_BOUND;
         for (int i = 0; i < n; i++) begin
            if (((s >> i) & 1) == 0) begin
               a = s | (1 << i);
               // each added element raises the rank by zero or one
               if (rank_mem[a] < rank_mem[s] || int'(rank_mem[a]) - int'(rank_mem[s]) > 1)
                  return mrac_pkg::V_INC;
               for (int j = i + 1; j < n; j++) begin
                  if (((s >> j) & 1) == 0) begin
                     b = s | (1 << j);
                     // r(S+i) + r(S+j) must cover r(S) + r(S+i+j)
                     if (int'(rank_mem[a]) + int'(rank_mem[b]) <
                         int'(rank_mem[s]) + int'(rank_mem[a | (1 << j)]))
                        return mrac_pkg::V_SUBMOD;
                  end
               end
            end
         end
      end
      // independent sets keep their size, everything else starts at zero
      for (int s = 0; s < size; s++) begin
         pc = $countones(s);
         rebuilt_mem[s] = (rank_mem[s] == pc) ? mrac_pkg::rank_type'(pc) : '0;
      end
      // largest independent subset, one sweep per element
      for (int i = 0; i < n; i++) begin
         for (int s = 0; s < size; s++) begin
            if (((s >> i) & 1) != 0 && rebuilt_mem[s ^ (1 << i)] > rebuilt_mem[s])
               rebuilt_mem[s] = rebuilt_mem[s ^ (1 << i)];
         end
      end
      for (int s = 0; s < size; s++) begin
         if (rebuilt_mem[s] != rank_mem[s]) return mrac_pkg::V_RECON;
      end
      return mrac_pkg::V_PASS;
   endfunction

   // longest walk the block may take over a passing table
   function automatic int check_cycles(input int n);
      return (1 << n) * (n * n + 4 * n + 7) + 4;
   endfunction

   // idle length for either side: mostly none or short, now and then long
   function automatic int gap_length();
      int roll;
      if (calm_phase || hold_left > 0) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // rank of the span of the chosen element vectors over GF(2)
   function automatic int span_rank(input int subset);
      logic [7:0] basis [8];
      logic [7:0] v;
      logic       placed;
      int         r;
      r = 0;
      for (int k = 0; k < 8; k++) basis[k] = '0;
      for (int e = 0; e < mrac_pkg::MAX_ELEMENTS; e++) begin
         if (((subset >> e) & 1) != 0) begin
            v = elem_vec[e];
            placed = 1'b0;
            for (int k = 7; k >= 0; k--) begin
               if (!placed && v[k]) begin
                  if (basis[k] == '0) begin
                     basis[k] = v;
                     placed = 1'b1;
                     r++;
                  end else begin
                     v = v ^ basis[k];
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // append one rank to the send queue
   task automatic add_rank(input mrac_pkg::rank_type value);
      pending_ranks = {pending_ranks, value};
   endtask

   // queue count ranks given as nibbles, lowest nibble is subset zero
   task automatic queue_hex(input int count, input logic [63:0] nibbles);
      for (int k = 0; k < count; k++) add_rank(nibbles[4*k +: 4]);
   endtask

   // queue one full table: intact rank function, one bad entry, or noise
   task automatic queue_table(input int n, input int style);
      mrac_pkg::rank_type vals [mrac_pkg::TABLE_DEPTH];
      int                 size;
      int                 dim;
      int                 spot;
      size = 1 << n;
      dim = $urandom_range(1, 8);
      for (int e = 0; e < mrac_pkg::MAX_ELEMENTS; e++)
         elem_vec[e] = 8'($urandom & ((1 << dim) - 1));
      for (int s = 0; s < size; s++) begin
         if (style < 80)
            vals[s] = mrac_pkg::rank_type'(span_rank(s));
         else if (style < 95)
            vals[s] = mrac_pkg::rank_type'($urandom_range(0, $countones(s) + 1));
         else
            vals[s] = mrac_pkg::rank_type'($urandom_range(0, 15));
      end
      if (style >= 80 && style < 95 && $urandom_range(0, 1) == 1) vals[0] = '0;
      // corrupt one entry
      if (style >= 45 && style < 80) begin
         spot = $urandom_range(0, size - 1);
         case ($urandom_range(0, 3))
            0: begin
               vals[spot] = vals[spot] + mrac_pkg::rank_type'(1);
            end
            1: begin
               vals[spot] = (vals[spot] == 0) ? mrac_pkg::rank_type'(1)
                                              : vals[spot] - mrac_pkg::rank_type'(1);
            end
            2: begin
               vals[spot] = mrac_pkg::rank_type'($urandom_range(0, 15));
            end
            default: begin
               vals[spot] = vals[spot] + mrac_pkg::rank_type'(2);
            end
         endcase
      end
      for (int s = 0; s < size; s++) add_rank(vals[s]);
   endtask

   // wait until nothing is in flight, then give the block time to settle
   task automatic wait_idle();
      while (pending_ranks.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (check_cycles(cur_n)) @(posedge clock);
   endtask

   task automatic write_element_count(input logic [mrac_pkg::CFG_W-1:0] value);
      cur_n = (value > mrac_pkg::MAX_ELEMENTS) ? mrac_pkg::MAX_ELEMENTS : int'(value);
      @(negedge clock);
      csr_element_count <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // rank item driver: one offer held until taken, gaps between items
   always @(negedge clock) begin : drive_ranks
      logic offer;
      offer = req_valid && !req_taken;
      if (reset) begin
         offer = 1'b0;
      end else if (!offer) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_ranks.size() != 0) begin
            req_rank_value <= pending_ranks.pop_front();
            offer = 1'b1;
            send_gap = gap_length();
         end
      end
      req_valid <= offer;
   end

   // verdict receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin : drive_ready
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = gap_length();
      end
   end

   // handshake monitor: tracks the table and checks every verdict item
   always @(posedge clock) begin : watch_ports
      mrac_pkg::verdict_type want;
      int                    n;
      int                    size;
      req_taken = 1'b0;
      if (!reset) begin
         // a register write drops any partly loaded table
         if (csr_valid && csr_ready) begin
            count_reg = csr_element_count;
            loaded = 0;
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            n = (count_reg > mrac_pkg::MAX_ELEMENTS) ? mrac_pkg::MAX_ELEMENTS
                                                     : int'(count_reg);
            size = 1 << n;
            if (loaded >= size) loaded = 0;
            rank_mem[loaded] = req_rank_value;
            loaded++;
            // the item that completes a table yields exactly one verdict
            if (loaded == size) begin
               loaded = 0;
               expected_verdicts = {expected_verdicts, judge_rank_table(n)};
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("verdict item %0d arrived with none expected", rsp_verdict);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_verdict !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("verdict mismatch: expected %0d, got %0d", want, rsp_verdict);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int                         phase;
      int                         sent_items;
      int                         tables;
      int                         roll;
      int                         extra;
      logic [mrac_pkg::CFG_W-1:0] setting;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero elements: every item is a whole table
      write_element_count(4'd0);
      queue_hex(1, 64'h0);
      queue_hex(1, 64'hF);            // empty set with top rank
      queue_hex(1, 64'h1);
      wait_idle();

      // one element: good table, then rank above subset size
      write_element_count(4'd1);
      queue_hex(2, 64'h10);
      queue_hex(2, 64'h20);
      wait_idle();

      // two elements: submodularity broken, rank drop, free pair
      write_element_count(4'd2);
      queue_hex(4, 64'h1000);
      queue_hex(4, 64'h0110);
      queue_hex(4, 64'h2110);
      // half a table, then a register write that must drop it
      queue_hex(2, 64'h55);
      wait_idle();
      write_element_count(4'd1);
      queue_hex(2, 64'h10);

      // random phases; the second one loads a single full-size table
      phase = 0;
      sent_items = 0;
      while (sent_items < 680) begin
         wait_idle();
         calm_phase = ($urandom_range(0, 4) == 0);
         if (phase == 0) begin
            setting = 4'd1;
         end else if (phase == 1) begin
            setting = 4'd15;          // saturates to the largest table
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 12) setting = 4'd0;
            else if (roll < 32) setting = 4'd1;
            else if (roll < 55) setting = 4'd2;
            else if (roll < 75) setting = 4'd3;
            else if (roll < 89) setting = 4'd4;
            else if (roll < 98) setting = 4'd5;
            else setting = mrac_pkg::CFG_W'($urandom_range(6, 7));
         end
         write_element_count(setting);
         if (phase == 0) begin
            calm_phase = 1'b0;
            tables = 80;
         end else if (cur_n == mrac_pkg::MAX_ELEMENTS) begin
            tables = 1;
         end else begin
            tables = $urandom_range(1, (cur_n < 6) ? (64 >> cur_n) : 1);
         end
         for (int t = 0; t < tables; t++)
            queue_table(cur_n, (cur_n == mrac_pkg::MAX_ELEMENTS) ? 0 : $urandom_range(0, 99));
         // sometimes leave a partial table for the next write to drop
         extra = 0;
         if (cur_n > 0 && cur_n < mrac_pkg::MAX_ELEMENTS && $urandom_range(0, 3) == 0) begin
            extra = $urandom_range(1, (1 << cur_n) - 1);
            for (int k = 0; k < extra; k++)
               add_rank(mrac_pkg::rank_type'($urandom_range(0, 15)));
         end
         sent_items += (tables << cur_n) + extra;
         // long receiver hold-off while the sender keeps pushing small tables
         if (phase == 0) begin
            @(posedge clock);
            hold_request = 1'b1;
         end
         phase++;
      end

      // drain and let the block settle
      while (pending_ranks.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (check_cycles(cur_n) + 20) @(posedge clock);
      if (expected_verdicts.size() != 0) error_count++;

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
